### hw/rtl/psqs_pkg.sv
// Shared types, codes and constants for the process state queue scheduler.
package psqs_pkg;

    localparam int PSQ_MAX_PROCS = 16;
    localparam int MAXP_W        = 5;
    localparam logic [MAXP_W-1:0] MAXP_RESET = 5'd16;

    typedef enum logic [2:0] {
        REQ_CREATE = 3'd0,
        REQ_KILL   = 3'd1,
        REQ_SLICE  = 3'd2,
        REQ_BLOCK  = 3'd3,
        REQ_WAKE   = 3'd4,
        REQ_SETPRI = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REJECT   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        Q_READY = 2'd0,
        Q_IO    = 2'd1,
        Q_OTHER = 2'd2
    } t_qid;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_WAKE,
        S_DISP,
        S_DISPW,
        S_RDRUN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rtime;
        logic [7:0]  prio;
    } t_entry;

endpackage

### hw/rtl/process_state_queue_scheduler_top.sv
// Process state queue scheduler: entry table, running slot and three FIFO queues.
// Every request goes through the start, dispatch, run-read and output states; create and set
// priority also scan the entry table one entry a cycle, and wake moves one entry to the ready
// queue. One request is handled at a time.
// The result register lets a new request be taken while the last result still waits.
// Reset (synchronous, active low) empties all queues, frees every entry and sets the limit to 16.
module process_state_queue_scheduler_top
    import psqs_pkg::*;
#(
    parameter int MAX_PROCS = PSQ_MAX_PROCS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // proc_id[7:0], run_time[23:8], new_priority[31:24], queue_sel[32], zero fill
    input  logic [39:0]       i_s_tdata,
    // req_type[2:0]
    input  logic [2:0]        i_s_tuser,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // status[1:0], run_valid[2], run_id[10:3], run_time_left[26:11],
    // run_priority[34:27], zero fill
    output logic [39:0]       o_m_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  logic [MAXP_W-1:0] i_cfg_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready
);

    localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int LW  = (CW > MAXP_W) ? CW : MAXP_W;
    localparam int QD  = 3 * (1 << IW);
    localparam int QAW = IW + 2;

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        ptr_inc = (p == IW'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Control state
    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    t_status               r_status, n_status;
    logic                  r_run_valid, n_run_valid;
    logic [IW-1:0]         r_run_idx, n_run_idx;
    logic [MAX_PROCS-1:0]  r_used, n_used;
    logic [CW-1:0]         r_live, n_live;
    logic [MAXP_W-1:0]     r_maxp;
    logic [IW-1:0]         r_head [3];
    logic [IW-1:0]         n_head [3];
    logic [IW-1:0]         r_tail [3];
    logic [IW-1:0]         n_tail [3];
    logic [CW-1:0]         r_qcnt [3];
    logic [CW-1:0]         n_qcnt [3];
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_pend, n_pend;
    logic [IW-1:0]         r_pidx, n_pidx;
    logic                  r_free_ok, n_free_ok;
    logic [IW-1:0]         r_free_idx, n_free_idx;
    logic                  r_out_valid, n_out_valid;

    // Request and result payload
    logic [7:0]            r_pid;
    logic [15:0]           r_rtime;
    logic [7:0]            r_npri;
    logic                  r_qsel;
    logic [39:0]           r_out_data, n_out_data;

    // Memories
    t_entry                r_tbl [MAX_PROCS];
    t_entry                r_tbl_rd;
    logic [IW-1:0]         r_qmem [QD];
    logic [IW-1:0]         r_q_rd;

    logic                  w_tbl_we, w_tbl_re;
    logic [IW-1:0]         w_tbl_waddr, w_tbl_raddr;
    t_entry                w_tbl_wdata;
    logic                  w_q_we, w_q_re;
    logic [QAW-1:0]        w_q_waddr, w_q_raddr;

    // One queue operation per cycle
    t_qid                  w_qop;
    logic                  w_push, w_pop;
    logic [IW-1:0]         w_push_idx;
    logic [IW-1:0]         w_sel_head, w_sel_tail;
    logic [CW-1:0]         w_sel_cnt;

    t_qid                  w_wq;
    logic [LW-1:0]         w_maxp_ext, w_lim;
    logic                  w_full;
    logic                  w_hit;
    logic                  w_s_xfer;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_data;
    assign w_s_xfer = i_s_tvalid && o_s_tready;

    assign w_wq = r_qsel ? Q_OTHER : Q_IO;
    assign w_maxp_ext = LW'(r_maxp);
    assign w_lim = (w_maxp_ext < LW'(MAX_PROCS)) ? w_maxp_ext : LW'(MAX_PROCS);
    assign w_full = (LW'(r_live) >= w_lim);
    assign w_hit = r_pend && r_used[r_pidx] && (r_tbl_rd.id == r_pid);

    assign w_sel_head = r_head[w_qop];
    assign w_sel_tail = r_tail[w_qop];
    assign w_sel_cnt = r_qcnt[w_qop];

    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_status = r_status;
        n_run_valid = r_run_valid;
        n_run_idx = r_run_idx;
        n_used = r_used;
        n_live = r_live;
        n_head = r_head;
        n_tail = r_tail;
        n_qcnt = r_qcnt;
        n_cnt = r_cnt;
        n_pend = r_pend;
        n_pidx = r_pidx;
        n_free_ok = r_free_ok;
        n_free_idx = r_free_idx;
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;
        w_tbl_we = 1'b0;
        w_tbl_re = 1'b0;
        w_tbl_waddr = r_pidx;
        w_tbl_raddr = r_cnt[IW-1:0];
        w_tbl_wdata = r_tbl_rd;
        w_qop = Q_READY;
        w_push = 1'b0;
        w_pop = 1'b0;
        w_push_idx = r_run_idx;
        w_q_we = 1'b0;
        w_q_re = 1'b0;
        w_q_waddr = '0;
        w_q_raddr = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_s_xfer) begin
                    n_req = t_req'(i_s_tuser);
                    n_status = ST_DONE;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DISP;
                unique case (r_req) inside
                    REQ_CREATE, REQ_SETPRI: begin
                        if (r_req == REQ_CREATE && w_full) begin
                            n_status = ST_REJECT;
                        end else begin
                            n_cnt = '0;
                            n_pend = 1'b0;
                            n_free_ok = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    REQ_KILL, REQ_SLICE, REQ_BLOCK: begin
                        if (!r_run_valid) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_run_valid = 1'b0;
                            if (r_req == REQ_KILL) begin
                                n_used[r_run_idx] = 1'b0;
                                if (r_live != '0) begin
                                    n_live = r_live - 1'b1;
                                end
                            end else begin
                                w_push = 1'b1;
                                w_push_idx = r_run_idx;
                                w_qop = (r_req == REQ_SLICE) ? Q_READY : w_wq;
                            end
                        end
                    end
                    REQ_WAKE: begin
                        if (r_qcnt[w_wq] == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_qop = w_wq;
                            w_pop = 1'b1;
                            n_state = S_WAKE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // One table read is issued per cycle; its entry is checked in the next cycle.
                if (w_hit) begin
                    n_pend = 1'b0;
                    n_state = S_DISP;
                    if (r_req == REQ_CREATE) begin
                        n_status = ST_REJECT;
                    end else begin
                        w_tbl_we = 1'b1;
                        w_tbl_waddr = r_pidx;
                        w_tbl_wdata = '{id: r_tbl_rd.id, rtime: r_tbl_rd.rtime, prio: r_npri};
                    end
                end else begin
                    if (r_pend && !r_used[r_pidx] && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free_idx = r_pidx;
                    end
                    if (r_cnt < CW'(MAX_PROCS)) begin
                        w_tbl_re = 1'b1;
                        w_tbl_raddr = r_cnt[IW-1:0];
                        n_pend = 1'b1;
                        n_pidx = r_cnt[IW-1:0];
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_state = S_DISP;
                            if (r_req == REQ_SETPRI) begin
                                n_status = ST_NOTFOUND;
                            end else if (r_free_ok) begin
                                w_tbl_we = 1'b1;
                                w_tbl_waddr = r_free_idx;
                                w_tbl_wdata = '{id: r_pid, rtime: r_rtime, prio: 8'd0};
                                n_used[r_free_idx] = 1'b1;
                                n_live = r_live + 1'b1;
                                w_push = 1'b1;
                                w_push_idx = r_free_idx;
                                w_qop = Q_READY;
                            end else begin
                                n_status = ST_REJECT;
                            end
                        end
                    end
                end
            end
            S_WAKE: begin
                w_push = 1'b1;
                w_push_idx = r_q_rd;
                w_qop = Q_READY;
                n_state = S_DISP;
            end
            S_DISP: begin
                if (!r_run_valid && r_qcnt[Q_READY] != '0) begin
                    w_qop = Q_READY;
                    w_pop = 1'b1;
                    n_state = S_DISPW;
                end else begin
                    n_state = S_RDRUN;
                end
            end
            S_DISPW: begin
                n_run_valid = 1'b1;
                n_run_idx = r_q_rd;
                n_state = S_RDRUN;
            end
            S_RDRUN: begin
                w_tbl_re = 1'b1;
                w_tbl_raddr = r_run_idx;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data = '0;
                    n_out_data[1:0] = r_status;
                    n_out_data[2] = r_run_valid;
                    if (r_run_valid) begin
                        n_out_data[10:3] = r_tbl_rd.id;
                        n_out_data[26:11] = r_tbl_rd.rtime;
                        n_out_data[34:27] = r_tbl_rd.prio;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push && (w_sel_cnt < CW'(MAX_PROCS))) begin
            w_q_we = 1'b1;
            w_q_waddr = {w_qop, w_sel_tail};
            n_tail[w_qop] = ptr_inc(w_sel_tail);
            n_qcnt[w_qop] = w_sel_cnt + 1'b1;
        end
        if (w_pop) begin
            w_q_re = 1'b1;
            w_q_raddr = {w_qop, w_sel_head};
            n_head[w_qop] = ptr_inc(w_sel_head);
            n_qcnt[w_qop] = w_sel_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req <= REQ_CREATE;
            r_status <= ST_DONE;
            r_run_valid <= 1'b0;
            r_run_idx <= '0;
            r_used <= '0;
            r_live <= '0;
            r_maxp <= MAXP_RESET;
            r_head <= '{default: '0};
            r_tail <= '{default: '0};
            r_qcnt <= '{default: '0};
            r_cnt <= '0;
            r_pend <= 1'b0;
            r_pidx <= '0;
            r_free_ok <= 1'b0;
            r_free_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req <= n_req;
            r_status <= n_status;
            r_run_valid <= n_run_valid;
            r_run_idx <= n_run_idx;
            r_used <= n_used;
            r_live <= n_live;
            if (i_cfg_valid && o_cfg_ready) begin
                r_maxp <= i_cfg_data;
            end
            r_head <= n_head;
            r_tail <= n_tail;
            r_qcnt <= n_qcnt;
            r_cnt <= n_cnt;
            r_pend <= n_pend;
            r_pidx <= n_pidx;
            r_free_ok <= n_free_ok;
            r_free_idx <= n_free_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_pid <= i_s_tdata[7:0];
            r_rtime <= i_s_tdata[23:8];
            r_npri <= i_s_tdata[31:24];
            r_qsel <= i_s_tdata[32];
        end
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl[w_tbl_waddr] <= w_tbl_wdata;
        end
        if (w_tbl_re) begin
            r_tbl_rd <= r_tbl[w_tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_qmem[w_q_waddr] <= w_push_idx;
        end
        if (w_q_re) begin
            r_q_rd <= r_qmem[w_q_raddr];
        end
    end

    // The live count always matches the number of allocated entries.
    a_live_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_live))
        else $error("live count differs from allocated entries");

    // Between requests every live entry is either running or waiting in exactly one queue.
    a_entries_accounted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        (int'(r_qcnt[0]) + int'(r_qcnt[1]) + int'(r_qcnt[2]) + int'(r_run_valid)
            == int'(r_live)))
        else $error("queue and running occupancy differ from live count");

    // Between requests nothing is left waiting in the ready queue while the slot is free.
    a_dispatch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_run_valid) |-> (r_qcnt[Q_READY] == '0))
        else $error("ready entry left undispatched");

    // A request is only started by an input transfer.
    a_start_needs_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !w_s_xfer) |=> (r_state == S_IDLE))
        else $error("request started without an input transfer");

endmodule
